// ----- hdl/lcdns_pkg.sv -----
// Shared types, codes and constants for the character LCD nibble sequencer.
// Used by every module under hdl/; it depends on nothing else.
package lcdns_pkg;

  // Command codes.
  localparam logic [3:0] OP_INIT       = 4'd0;
  localparam logic [3:0] OP_CLEAR      = 4'd1;
  localparam logic [3:0] OP_SET_CURSOR = 4'd2;
  localparam logic [3:0] OP_WRITE_CHAR = 4'd3;
  localparam logic [3:0] OP_DISPLAY    = 4'd4;
  localparam logic [3:0] OP_CURSOR     = 4'd5;
  localparam logic [3:0] OP_BLINK      = 4'd6;
  localparam logic [3:0] OP_CGRAM_ADDR = 4'd7;
  localparam logic [3:0] OP_CGRAM_ROW  = 4'd8;

  // Register-select levels.
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // Timing in microseconds.
  localparam logic [15:0] POWER_UP_WAIT_US = 16'd50000;
  localparam logic [12:0] SETTLE_US        = 13'd40;
  localparam logic [12:0] INIT_FIRST_US    = 13'd5040;
  localparam logic [12:0] INIT_SECOND_US   = 13'd140;
  localparam logic [12:0] CLEAR_SETTLE_US  = 13'd2040;

  // Instruction bytes.
  localparam logic [7:0] FUNCTION_SET  = 8'h20;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] CONTROL_BASE  = 8'h08;
  localparam logic [7:0] INIT_CONTROL  = 8'h0C;
  localparam logic [7:0] CLEAR_BYTE    = 8'h01;
  localparam logic [7:0] CGRAM_BASE    = 8'h40;
  localparam logic [7:0] DDRAM_BASE    = 8'h80;
  localparam logic [4:0] CGRAM_ROW_MASK = 5'h1f;

  // Wake-up nibbles of the power-up sequence.
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

  // Step counter of the back end.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

  // Default depth of the queue between front and back.
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [3:0] operation;
    logic [1:0] row;
    logic [6:0] column;
    logic [7:0] data_byte;
    logic       flag;
    logic [2:0] glyph_code;
  } command_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } result_t;

  // One unit of work for the back end: either the whole power-up sequence
  // (data holds the function-set byte) or a single byte transfer.
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic       long_settle;
    logic [7:0] data;
  } job_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

  // One nibble of the power-up sequence, selected by step.
  function automatic result_t init_nibble(input logic [STEP_W-1:0] step,
                                          input logic [7:0] fset);
    result_t r;
    r = '0;
    r.reg_select    = RS_COMMAND;
    r.wait_after_us = SETTLE_US;
    case (step)
      4'd0: begin
        r.nibble         = WAKE_NIBBLE;
        r.wait_before_us = POWER_UP_WAIT_US;
        r.wait_after_us  = INIT_FIRST_US;
      end
      4'd1: begin
        r.nibble        = WAKE_NIBBLE;
        r.wait_after_us = INIT_SECOND_US;
      end
      4'd2:  r.nibble = WAKE_NIBBLE;
      4'd3:  r.nibble = FOUR_BIT_NIBBLE;
      4'd4:  r.nibble = fset[7:4];
      4'd5:  r.nibble = fset[3:0];
      4'd6:  r.nibble = ENTRY_MODE[7:4];
      4'd7:  r.nibble = ENTRY_MODE[3:0];
      4'd8:  r.nibble = INIT_CONTROL[7:4];
      4'd9:  r.nibble = INIT_CONTROL[3:0];
      4'd10: r.nibble = CLEAR_BYTE[7:4];
      4'd11: begin
        r.nibble        = CLEAR_BYTE[3:0];
        r.wait_after_us = CLEAR_SETTLE_US;
        r.last          = 1'b1;
      end
      default: r.nibble = 4'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer: configuration register,
// front end, job queue and back end. Depends on lcdns_pkg and the lcdns_* modules.
//
// Usage. Commands enter through a queue-style port: a command request is
// taken at a rising edge where push is high and full is low. Results leave
// through a second queue-style port: while empty is low the oldest nibble
// transfer is on result, and it is taken at an edge where pop is high.
// Each result is one enable strobe: register select, D7..D4, the wait before
// the strobe and the settle time after it; last marks a command's final one.
//
// Throughput. A command is taken whenever the job queue has room
// (QUEUE_DEPTH entries), so commands can arrive back to back. The back end
// issues one nibble per cycle while pop is high or no result is held:
// power-up init yields 12 nibbles, every other command 2, and unused
// operation codes none. The back end's single nibble output register sets the
// sustained rate. With the back end idle, a command's first nibble passes
// through the job queue, then the back end's output register, before it
// shows on result.
// Stalls. When pop stays low the result holds, the back end stops and the
// queue fills; full then rises and commands wait upstream.
// Reset clears both queues and restores display on, cursor and blink off,
// and two-line mode. cfg_ready is always high; two_line takes effect for
// the next init command.
module char_lcd_nibble_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lcdns_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  lcdns_pkg::command_t command,
  input  logic                push,
  output logic                full,
  output lcdns_pkg::result_t  result,
  output logic                empty,
  input  logic                pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_two_line
);
  import lcdns_pkg::*;

  logic two_line;
  logic q_full, q_valid, q_push, q_take;
  job_t front_job, head_job;

  assign cfg_ready = 1'b1;

  // Function-set line mode; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      two_line <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      two_line <= cfg_two_line;
    end
  end

  lcdns_front u_front (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .push       (push),
    .two_line   (two_line),
    .queue_full (q_full),
    .full       (full),
    .job_push   (q_push),
    .job        (front_job)
  );

  lcdns_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (front_job),
    .full    (q_full),
    .valid   (q_valid),
    .job_out (head_job),
    .take    (q_take)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (head_job),
    .job_take  (q_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  // Reset leaves no stale result and room for commands.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full asserted after reset");

  // Only the first wake-up nibble of init waits before its strobe.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.wait_before_us != 16'd0) |->
      (result.nibble == WAKE_NIBBLE && result.reg_select == RS_COMMAND &&
       !result.last))
    else $error("power-up wait on an unexpected nibble");

  // Data-register writes never carry a long settle time.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.reg_select == RS_DATA) |-> (result.wait_after_us == SETTLE_US))
    else $error("data nibble with long settle time");

  // A job leaves the queue only on a command's final nibble.
  assert property (@(posedge clk) disable iff (rst)
    q_take |=> (!empty && result.last))
    else $error("job retired without a final nibble");

endmodule

// ----- hdl/lcdns_front.sv -----
// Front end: accepts commands, keeps the display/cursor/blink flags and
// turns each known command into one job; unused codes give none. Depends on lcdns_pkg.
module lcdns_front (
  input  logic               clk,
  input  logic               rst,
  input  lcdns_pkg::command_t command,
  input  logic               push,
  input  logic               two_line,
  input  logic               queue_full,
  output logic               full,
  output logic               job_push,
  output lcdns_pkg::job_t    job
);
  import lcdns_pkg::*;

  logic display_on, cursor_shown, blink_on;
  logic display_on_next, cursor_shown_next, blink_on_next;
  logic accept, known_op;
  logic [7:0] cursor_addr;

  assign full   = queue_full;
  assign accept = push && !queue_full;
  assign job_push = accept && known_op;
  assign cursor_addr = {1'b0, command.column} + row_offset(command.row);

  always_comb begin
    display_on_next   = display_on;
    cursor_shown_next = cursor_shown;
    blink_on_next     = blink_on;
    known_op          = 1'b1;
    job               = '0;
    job.reg_select    = RS_COMMAND;
    case (command.operation)
      OP_INIT: begin
        display_on_next   = 1'b1;
        cursor_shown_next = 1'b0;
        blink_on_next     = 1'b0;
        job.is_init       = 1'b1;
        job.data          = FUNCTION_SET | {4'b0, two_line, 3'b0};
      end
      OP_CLEAR: begin
        job.data        = CLEAR_BYTE;
        job.long_settle = 1'b1;
      end
      OP_SET_CURSOR: job.data = cursor_addr | DDRAM_BASE;
      OP_WRITE_CHAR: begin
        job.reg_select = RS_DATA;
        job.data       = command.data_byte;
      end
      OP_DISPLAY: display_on_next   = command.flag;
      OP_CURSOR:  cursor_shown_next = command.flag;
      OP_BLINK:   blink_on_next     = command.flag;
      OP_CGRAM_ADDR: job.data = CGRAM_BASE | {2'b0, command.glyph_code, 3'b0};
      OP_CGRAM_ROW: begin
        job.reg_select = RS_DATA;
        job.data       = {3'b0, command.data_byte[4:0] & CGRAM_ROW_MASK};
      end
      default: known_op = 1'b0;
    endcase
    if (command.operation inside {OP_DISPLAY, OP_CURSOR, OP_BLINK}) begin
      job.data = CONTROL_BASE |
                 {5'b0, display_on_next, cursor_shown_next, blink_on_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_on   <= 1'b1;
      cursor_shown <= 1'b0;
      blink_on     <= 1'b0;
    end else if (accept) begin
      display_on   <= display_on_next;
      cursor_shown <= cursor_shown_next;
      blink_on     <= blink_on_next;
    end
  end

endmodule

// ----- hdl/lcdns_job_queue.sv -----
// Small register queue that carries jobs from the front end to the back end.
// Depends on lcdns_pkg for the job type.
module lcdns_job_queue #(
  parameter int unsigned DEPTH = lcdns_pkg::JOB_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdns_pkg::job_t job_in,
  output logic            full,
  output logic            valid,
  output lcdns_pkg::job_t job_out,
  input  logic            take
);
  import lcdns_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_take;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign job_out = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/lcdns_back.sv -----
// Back end: walks each job nibble by nibble into the output register.
// Depends on lcdns_pkg for the job and result types and the timing constants.
module lcdns_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  lcdns_pkg::job_t    job,
  output logic               job_take,
  output lcdns_pkg::result_t result,
  output logic               empty,
  input  logic               pop
);
  import lcdns_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic              out_valid;
  logic              advance;
  result_t           nib_next;

  assign empty     = !out_valid;
  assign advance   = job_valid && (!out_valid || pop);
  assign last_step = job.is_init ? INIT_LAST_STEP : BYTE_LAST_STEP;
  assign job_take  = advance && (step == last_step);

  always_comb begin
    if (job.is_init) begin
      nib_next = init_nibble(step, job.data);
    end else begin
      nib_next                = '0;
      nib_next.reg_select     = job.reg_select;
      nib_next.nibble         = (step == '0) ? job.data[7:4] : job.data[3:0];
      nib_next.wait_after_us  = (step != '0 && job.long_settle) ? CLEAR_SETTLE_US
                                                                : SETTLE_US;
      nib_next.last           = (step == last_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        step      <= job_take ? '0 : step + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= nib_next;
    end
  end

endmodule

// ----- tb/char_lcd_nibble_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the character LCD nibble sequencer. It predicts the nibble
// transfers of each accepted command request and checks them in order.
// Depends on lcdns_pkg for the command and result types and the constants.
module char_lcd_nibble_checker (
  input  logic                clk,
  input  logic                rst,
  input  lcdns_pkg::command_t command,
  input  logic                push,
  input  logic                full,
  input  lcdns_pkg::result_t  result,
  input  logic                empty,
  input  logic                pop,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_two_line,
  output int                  mismatches,
  output int                  pending,
  output int                  nibbles_checked
);
  import lcdns_pkg::*;

  localparam int MAX_REPORTS = 30;

  result_t expected_nibbles[$];
  logic    two_line_mode;
  logic    display_on;
  logic    cursor_shown;
  logic    blink_on;
  int      error_count;
  int      checked_count;

  function automatic logic [7:0] cursor_address(input logic [1:0] row,
                                                input logic [6:0] column);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return (base + {1'b0, column}) | DDRAM_BASE;
  endfunction

  function automatic logic [7:0] control_byte();
    return CONTROL_BASE | {5'b0, display_on, cursor_shown, blink_on};
  endfunction

  task automatic queue_nibble(input logic rs, input logic [3:0] nib,
                              input logic [15:0] pre_us, input logic [12:0] post_us,
                              input logic last);
    result_t r;
    r.reg_select     = rs;
    r.nibble         = nib;
    r.wait_before_us = pre_us;
    r.wait_after_us  = post_us;
    r.last           = last;
    expected_nibbles.push_back(r);
  endtask

  // High nibble first; only the low nibble carries the long settle time.
  task automatic queue_byte(input logic rs, input logic [7:0] b,
                            input logic [12:0] after_low, input logic last);
    queue_nibble(rs, b[7:4], 16'd0, SETTLE_US, 1'b0);
    queue_nibble(rs, b[3:0], 16'd0, after_low, last);
  endtask

  task automatic expand_command(input command_t c);
    case (c.operation)
      OP_INIT: begin
        // Power-up puts the flags back to their reset values first.
        display_on   = 1'b1;
        cursor_shown = 1'b0;
        blink_on     = 1'b0;
        queue_nibble(RS_COMMAND, WAKE_NIBBLE, POWER_UP_WAIT_US, INIT_FIRST_US, 1'b0);
        queue_nibble(RS_COMMAND, WAKE_NIBBLE, 16'd0, INIT_SECOND_US, 1'b0);
        queue_nibble(RS_COMMAND, WAKE_NIBBLE, 16'd0, SETTLE_US, 1'b0);
        queue_nibble(RS_COMMAND, FOUR_BIT_NIBBLE, 16'd0, SETTLE_US, 1'b0);
        queue_byte(RS_COMMAND, FUNCTION_SET | {4'b0, two_line_mode, 3'b0}, SETTLE_US, 1'b0);
        queue_byte(RS_COMMAND, ENTRY_MODE, SETTLE_US, 1'b0);
        queue_byte(RS_COMMAND, control_byte(), SETTLE_US, 1'b0);
        queue_byte(RS_COMMAND, CLEAR_BYTE, CLEAR_SETTLE_US, 1'b1);
      end
      OP_CLEAR:      queue_byte(RS_COMMAND, CLEAR_BYTE, CLEAR_SETTLE_US, 1'b1);
      OP_SET_CURSOR: queue_byte(RS_COMMAND, cursor_address(c.row, c.column), SETTLE_US, 1'b1);
      OP_WRITE_CHAR: queue_byte(RS_DATA, c.data_byte, SETTLE_US, 1'b1);
      OP_DISPLAY, OP_CURSOR, OP_BLINK: begin
        if (c.operation == OP_DISPLAY) begin
          display_on = c.flag;
        end else if (c.operation == OP_CURSOR) begin
          cursor_shown = c.flag;
        end else begin
          blink_on = c.flag;
        end
        queue_byte(RS_COMMAND, control_byte(), SETTLE_US, 1'b1);
      end
      OP_CGRAM_ADDR: queue_byte(RS_COMMAND, CGRAM_BASE | {2'b0, c.glyph_code, 3'b0},
                                SETTLE_US, 1'b1);
      OP_CGRAM_ROW:  queue_byte(RS_DATA, c.data_byte & {3'b0, CGRAM_ROW_MASK},
                                SETTLE_US, 1'b1);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (error_count < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
      error_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      expected_nibbles.delete();
      two_line_mode = 1'b1;
      display_on    = 1'b1;
      cursor_shown  = 1'b0;
      blink_on      = 1'b0;
      error_count   = 0;
      checked_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        two_line_mode = cfg_two_line;
      end
      if (pop && !empty) begin
        if (expected_nibbles.size() == 0) begin
          if (error_count < MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time, result);
          end
          error_count++;
        end else begin
          want = expected_nibbles.pop_front();
          check_field("reg_select", want.reg_select, result.reg_select);
          check_field("nibble", want.nibble, result.nibble);
          check_field("wait_before_us", want.wait_before_us, result.wait_before_us);
          check_field("wait_after_us", want.wait_after_us, result.wait_after_us);
          check_field("last", want.last, result.last);
          checked_count++;
        end
      end
      if (push && !full) begin
        expand_command(command);
      end
    end
    pending         <= expected_nibbles.size();
    mismatches      <= error_count;
    nibbles_checked <= checked_count;
  end

endmodule

// ----- tb/char_lcd_nibble_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Top of the testbench for the character LCD nibble sequencer: clock, reset,
// command and configuration stimulus, result pacing and the final verdict.
// Depends on lcdns_pkg, char_lcd_nibble_sequencer and char_lcd_nibble_checker.
module char_lcd_nibble_sequencer_tb;
  import lcdns_pkg::*;

  // Random commands over all configuration phases together, counting only codes the block acts on.
  localparam int RANDOM_ITEMS = 400;
  localparam int PHASES       = 4;
  // Cycles of quiet before a configuration write, after the last predicted
  // nibble has come out.
  localparam int IDLE_WAIT    = 8;
  // Cycles to keep watching after the last expected result, to catch extras.
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 4_000_000;

  // Codes past the last operation; the block must ignore them.
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  command_t command      = '0;
  logic     push         = 1'b0;
  logic     full;
  result_t  result;
  logic     empty;
  logic     pop          = 1'b0;
  logic     cfg_valid    = 1'b0;
  logic     cfg_ready;
  logic     cfg_two_line = 1'b1;

  int mismatches;
  int pending;
  int nibbles_checked;
  int commands_sent = 0;
  int inits_sent    = 0;
  int ignored_sent  = 0;
  // Number of upcoming command requests that go out with no gap at all.
  int calm_items    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_lcd_nibble_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .push         (push),
    .full         (full),
    .result       (result),
    .empty        (empty),
    .pop          (pop),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_two_line (cfg_two_line)
  );

  char_lcd_nibble_checker nibble_check (
    .clk             (clk),
    .rst             (rst),
    .command         (command),
    .push            (push),
    .full            (full),
    .result          (result),
    .empty           (empty),
    .pop             (pop),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_two_line    (cfg_two_line),
    .mismatches      (mismatches),
    .pending         (pending),
    .nibbles_checked (nibbles_checked)
  );

  function automatic command_t make_command(input logic [3:0] op, input logic [1:0] row,
                                            input logic [6:0] column, input logic [7:0] data,
                                            input logic flag, input logic [2:0] glyph);
    command_t c;
    c.operation  = op;
    c.row        = row;
    c.column     = column;
    c.data_byte  = data;
    c.flag       = flag;
    c.glyph_code = glyph;
    return c;
  endfunction

  // All fields are random, also the ones the chosen operation does not use.
  // Init is kept rare since it yields twelve nibbles, and a few requests carry
  // codes the block should drop.
  function automatic command_t random_command();
    command_t    c;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    c.row        = 2'($urandom_range(0, 3));
    c.column     = 7'($urandom_range(0, 127));
    c.data_byte  = 8'($urandom_range(0, 255));
    c.flag       = 1'($urandom_range(0, 1));
    c.glyph_code = 3'($urandom_range(0, 7));
    if (pick < 8) begin
      c.operation = OP_INIT;
    end else if (pick < 14) begin
      c.operation = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end else begin
      c.operation = 4'($urandom_range(OP_CLEAR, OP_CGRAM_ROW));
    end
    return c;
  endfunction

  // Gap before the next command request: mostly none or a few cycles, now and
  // then a long one, and sometimes a run of requests sent back to back.
  function automatic int next_gap();
    int unsigned pick;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      calm_items = $urandom_range(10, 30);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offers one command request and returns at the edge that takes it. Push
  // stays high when the next request follows with no gap, so it is never
  // lowered and raised within one time step.
  task automatic send(input command_t c);
    int gap;
    gap = next_gap();
    if (gap > 0 && push) begin
      push <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    command <= c;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    commands_sent++;
    if (c.operation == OP_INIT) begin
      inits_sent++;
    end else if (c.operation > OP_CGRAM_ROW) begin
      ignored_sent++;
    end
  endtask

  // Waits until every predicted nibble has come out, then writes the mode.
  task automatic write_two_line(input logic two_line);
    if (push) begin
      push <= 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_two_line <= two_line;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result side: pop is held high or low for runs of random length. Long
  // open runs let the back end stream; long stalls back up the job queue
  // until full rises.
  initial begin : pop_pacing
    int unsigned run_left;
    int unsigned pick;
    logic        level;
    run_left = 0;
    level    = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          level    = 1'b1;
          run_left = $urandom_range(20, 60);
        end else if (pick < 60) begin
          level    = 1'b1;
          run_left = $urandom_range(1, 6);
        end else if (pick < 92) begin
          level    = 1'b0;
          run_left = $urandom_range(1, 3);
        end else begin
          level    = 1'b0;
          run_left = $urandom_range(10, 30);
        end
      end
      run_left--;
      pop <= level;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: %0d nibbles still expected", pending);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int accepted;
    int phase;
    command_t c;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Power-up init with the reset mode (two lines), then every
    // operation with its fields at their extremes.
    send(make_command(OP_INIT, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_CLEAR, 2'd3, 7'd127, 8'hFF, 1'b1, 3'd7));
    send(make_command(OP_SET_CURSOR, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_SET_CURSOR, 2'd1, 7'd127, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_SET_CURSOR, 2'd2, 7'd127, 8'hFF, 1'b1, 3'd7));
    send(make_command(OP_SET_CURSOR, 2'd3, 7'd127, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_WRITE_CHAR, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_WRITE_CHAR, 2'd3, 7'd127, 8'hFF, 1'b1, 3'd7));
    // Flag commands: each updates its own flag before the control byte goes out.
    send(make_command(OP_DISPLAY, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_CURSOR, 2'd0, 7'd0, 8'h00, 1'b1, 3'd0));
    send(make_command(OP_BLINK, 2'd0, 7'd0, 8'h00, 1'b1, 3'd0));
    send(make_command(OP_DISPLAY, 2'd0, 7'd0, 8'h00, 1'b1, 3'd0));
    // An init with cursor and blink on must still send the reset control byte.
    send(make_command(OP_INIT, 2'd3, 7'd127, 8'hFF, 1'b1, 3'd7));
    send(make_command(OP_CGRAM_ADDR, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_CGRAM_ADDR, 2'd3, 7'd127, 8'hFF, 1'b1, 3'd7));
    // CGRAM rows keep only the low five bits of the bitmap.
    send(make_command(OP_CGRAM_ROW, 2'd0, 7'd0, 8'hFF, 1'b0, 3'd0));
    send(make_command(OP_CGRAM_ROW, 2'd0, 7'd0, 8'hE0, 1'b0, 3'd0));
    // Unused codes yield nothing; the cursor command after them shows that the
    // flags were left alone.
    send(make_command(OP_UNUSED_FIRST, 2'd1, 7'd5, 8'h5A, 1'b0, 3'd2));
    send(make_command(OP_UNUSED_LAST, 2'd2, 7'd9, 8'hA5, 1'b1, 3'd5));
    send(make_command(OP_CURSOR, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));

    // One-line mode must drop bit 3 of the function-set byte.
    write_two_line(1'b0);
    send(make_command(OP_INIT, 2'd0, 7'd0, 8'h00, 1'b0, 3'd0));
    send(make_command(OP_WRITE_CHAR, 2'd1, 7'd64, 8'h41, 1'b0, 3'd1));

    // Random part, split into phases that alternate the line mode.
    for (phase = 0; phase < PHASES; phase++) begin
      write_two_line(phase % 2 == 0);
      accepted = 0;
      while (accepted < RANDOM_ITEMS / PHASES) begin
        c = random_command();
        send(c);
        if (c.operation <= OP_CGRAM_ROW) begin
          accepted++;
        end
      end
    end

    // Drain: every predicted nibble must arrive, and nothing after it.
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d command requests (%0d inits, %0d unused codes)",
             commands_sent, inits_sent, ignored_sent);
    $display("in both line modes, with %0d nibble transfers checked.", nibbles_checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lcdns_pkg.sv
hdl/lcdns_front.sv
hdl/lcdns_job_queue.sv
hdl/lcdns_back.sv
hdl/char_lcd_nibble_sequencer.sv
tb/char_lcd_nibble_checker.sv
tb/char_lcd_nibble_sequencer_tb.sv
